// ----- rtl/wpr_pkg.sv -----
package wpr_pkg;

  // Default table depth.
  localparam int unsigned WPR_MAX_ENTRIES_DEF = 64;

  // Fixed field widths.
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEFT_W   = 7;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STS_OK       = 3'd0;
  localparam status_t STS_EMPTY    = 3'd1;
  localparam status_t STS_RANGE    = 3'd2;
  localparam status_t STS_OVERFLOW = 3'd3;
  localparam status_t STS_FULL     = 3'd4;

  // One stored table entry.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [POS_W-1:0]    position;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decide;
    logic scan;
    logic shift;
    logic commit;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic roll;
    logic remove;
    logic roll_go;
    logic hit;
    logic shift_done;
  } sts_t;

endpackage

// ----- rtl/wpr_dp.sv -----
module wpr_dp #(
  parameter int unsigned MAX_ENTRIES = wpr_pkg::WPR_MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_action,
  input  logic [wpr_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic                          in_first_of_set,
  input  logic [wpr_pkg::WEIGHT_W-1:0]  in_draw,
  input  logic                          in_remove_picked,
  input  wpr_pkg::cmd_t                 cmd,
  output wpr_pkg::sts_t                 sts,
  output logic [wpr_pkg::STATUS_W-1:0]  out_status,
  output logic [wpr_pkg::POS_W-1:0]     out_picked_position,
  output logic [wpr_pkg::LEFT_W-1:0]    out_entries_left,
  output logic [wpr_pkg::WEIGHT_W-1:0]  out_total_weight
);
  import wpr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  // Entry table, one write and one registered read per cycle.
  entry_t mem [MAX_ENTRIES];
  entry_t rdata_r;
  logic   wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  entry_t wr_data;

  // Captured item.
  logic                act_r, act_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic                first_r, first_nxt;
  logic [WEIGHT_W-1:0] draw_r, draw_nxt;
  logic                remove_r, remove_nxt;

  // Architectural state.
  logic [CW-1:0]       count_r, count_nxt;
  logic [WEIGHT_W-1:0] total_r, total_nxt;
  logic [POS_W-1:0]    next_pos_r, next_pos_nxt;
  logic                ovf_r, ovf_nxt;

  // Scan and compaction.
  logic [CW-1:0]       scan_idx_r, scan_idx_nxt;
  logic [AW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [WEIGHT_W-1:0] run_r, run_nxt;
  logic [WEIGHT_W-1:0] hit_w_r, hit_w_nxt;
  logic [CW-1:0]       shift_idx_r, shift_idx_nxt;
  logic                wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]       wr_addr_r, wr_addr_nxt;

  // Result and output registers.
  status_t             res_status_r, res_status_nxt;
  logic [POS_W-1:0]    res_pick_r, res_pick_nxt;
  status_t             o_status_r, o_status_nxt;
  logic [POS_W-1:0]    o_pick_r, o_pick_nxt;
  logic [LEFT_W-1:0]   o_left_r, o_left_nxt;
  logic [WEIGHT_W-1:0] o_total_r, o_total_nxt;

  logic [CW-1:0]       eff_count;
  logic [WEIGHT_W-1:0] eff_total;
  logic                eff_ovf;
  logic [POS_W-1:0]    eff_pos;
  logic [WEIGHT_W:0]   load_sum;
  logic [WEIGHT_W:0]   scan_sum;
  logic                hit;
  logic                roll_go;
  logic                shift_more;

  // A first-of-set load sees an empty table.
  assign eff_count = first_r ? '0 : count_r;
  assign eff_total = first_r ? '0 : total_r;
  assign eff_ovf   = first_r ? 1'b0 : ovf_r;
  assign eff_pos   = first_r ? '0 : next_pos_r;

  assign load_sum   = {1'b0, eff_total} + {1'b0, weight_r};
  assign scan_sum   = {1'b0, run_r} + {1'b0, rdata_r.weight};
  assign hit        = chk_vld_r && ({1'b0, draw_r} <= scan_sum);
  assign roll_go    = !ovf_r && (count_r != '0) && (draw_r != '0) && (draw_r <= total_r);
  assign shift_more = shift_idx_r < count_r;

  assign sts.roll       = act_r;
  assign sts.remove     = remove_r;
  assign sts.roll_go    = roll_go;
  assign sts.hit        = hit;
  assign sts.shift_done = !shift_more && !wr_pend_r;

  always_comb begin
    act_nxt        = act_r;
    weight_nxt     = weight_r;
    first_nxt      = first_r;
    draw_nxt       = draw_r;
    remove_nxt     = remove_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    next_pos_nxt   = next_pos_r;
    ovf_nxt        = ovf_r;
    scan_idx_nxt   = scan_idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    run_nxt        = run_r;
    hit_w_nxt      = hit_w_r;
    shift_idx_nxt  = shift_idx_r;
    wr_pend_nxt    = wr_pend_r;
    wr_addr_nxt    = wr_addr_r;
    res_status_nxt = res_status_r;
    res_pick_nxt   = res_pick_r;
    o_status_nxt   = o_status_r;
    o_pick_nxt     = o_pick_r;
    o_left_nxt     = o_left_r;
    o_total_nxt    = o_total_r;

    // Compaction writes land in the cycle after their read.
    wr_en   = wr_pend_r;
    wr_addr = wr_addr_r;
    wr_data = rdata_r;
    rd_addr = scan_idx_r[AW-1:0];

    if (cmd.capture) begin
      act_nxt    = in_action;
      weight_nxt = in_weight;
      first_nxt  = in_first_of_set;
      draw_nxt   = in_draw;
      remove_nxt = in_remove_picked;
    end

    if (cmd.decide) begin
      scan_idx_nxt = '0;
      chk_vld_nxt  = 1'b0;
      run_nxt      = '0;
      res_pick_nxt = '0;
      if (!act_r) begin
        count_nxt    = eff_count;
        total_nxt    = eff_total;
        ovf_nxt      = eff_ovf;
        next_pos_nxt = eff_pos + 1'b1;
        if (eff_ovf) begin
          res_status_nxt = STS_OVERFLOW;
        end else if (weight_r == '0) begin
          res_status_nxt = STS_OK;
        end else if (eff_count >= CW'(MAX_ENTRIES)) begin
          res_status_nxt = STS_FULL;
        end else if (load_sum[WEIGHT_W]) begin
          ovf_nxt        = 1'b1;
          res_status_nxt = STS_OVERFLOW;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = eff_count[AW-1:0];
          wr_data        = '{weight: weight_r, position: eff_pos};
          count_nxt      = eff_count + 1'b1;
          total_nxt      = load_sum[WEIGHT_W-1:0];
          res_status_nxt = STS_OK;
        end
      end else begin
        if (ovf_r) begin
          res_status_nxt = STS_OVERFLOW;
        end else if (count_r == '0) begin
          res_status_nxt = STS_EMPTY;
        end else if (!roll_go) begin
          res_status_nxt = STS_RANGE;
        end else begin
          res_status_nxt = STS_OK;
        end
      end
    end

    if (cmd.scan) begin
      scan_idx_nxt = scan_idx_r + 1'b1;
      chk_idx_nxt  = scan_idx_r[AW-1:0];
      chk_vld_nxt  = 1'b1;
      if (chk_vld_r) begin
        run_nxt = scan_sum[WEIGHT_W-1:0];
      end
      if (hit) begin
        res_pick_nxt  = rdata_r.position;
        hit_w_nxt     = rdata_r.weight;
        shift_idx_nxt = CW'(chk_idx_r) + CW'(1);
        wr_pend_nxt   = 1'b0;
      end
    end

    if (cmd.shift) begin
      rd_addr = shift_idx_r[AW-1:0];
      if (shift_more) begin
        shift_idx_nxt = shift_idx_r + 1'b1;
        wr_pend_nxt   = 1'b1;
        wr_addr_nxt   = AW'(shift_idx_r - 1'b1);
      end else begin
        wr_pend_nxt = 1'b0;
      end
    end

    if (cmd.commit) begin
      count_nxt = count_r - 1'b1;
      total_nxt = total_r - hit_w_r;
    end

    if (cmd.publish) begin
      o_status_nxt = res_status_r;
      o_pick_nxt   = res_pick_r;
      o_left_nxt   = LEFT_W'(count_r);
      o_total_nxt  = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      total_r    <= '0;
      next_pos_r <= '0;
      ovf_r      <= 1'b0;
      chk_vld_r  <= 1'b0;
      wr_pend_r  <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      total_r    <= total_nxt;
      next_pos_r <= next_pos_nxt;
      ovf_r      <= ovf_nxt;
      chk_vld_r  <= chk_vld_nxt;
      wr_pend_r  <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    weight_r     <= weight_nxt;
    first_r      <= first_nxt;
    draw_r       <= draw_nxt;
    remove_r     <= remove_nxt;
    scan_idx_r   <= scan_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    run_r        <= run_nxt;
    hit_w_r      <= hit_w_nxt;
    shift_idx_r  <= shift_idx_nxt;
    wr_addr_r    <= wr_addr_nxt;
    res_status_r <= res_status_nxt;
    res_pick_r   <= res_pick_nxt;
    o_status_r   <= o_status_nxt;
    o_pick_r     <= o_pick_nxt;
    o_left_r     <= o_left_nxt;
    o_total_r    <= o_total_nxt;
  end

  assign out_status          = o_status_r;
  assign out_picked_position = o_pick_r;
  assign out_entries_left    = o_left_r;
  assign out_total_weight    = o_total_r;

  // The table never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds table depth");

  // Removal only ever follows a pick from a non-empty table.
  a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (count_r != '0) && !wr_pend_r)
    else $error("removal committed on empty table or with a write pending");

endmodule

// ----- rtl/wpr_ctrl.sv -----
module wpr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  wpr_pkg::sts_t sts,
  output wpr_pkg::cmd_t cmd
);
  import wpr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   out_free;

  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.roll && sts.roll_go) state_nxt = S_SCAN;
        else                         state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (sts.hit) state_nxt = sts.remove ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        if (sts.shift_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_DECIDE: cmd.decide = 1'b1;
      S_SCAN:   cmd.scan   = 1'b1;
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        cmd.commit = sts.shift_done;
      end
      S_DONE:   cmd.publish = out_free;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.publish)   out_vld_nxt = 1'b1;
    else if (out_stall) out_vld_nxt = out_vld_r;
    else               out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;

  // An accepted item always moves straight on to its decision step.
  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> state_r == S_DECIDE)
    else $error("accepted item did not reach decision step");

  // Publishing a result always presents it on the output.
  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid)
    else $error("published result not presented");

  // A finished removal always goes on to deliver its result.
  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_DONE)
    else $error("removal commit not followed by result delivery");

endmodule

// ----- rtl/weighted_pick_with_removal.sv -----
// A load or a rejected roll passes from its transfer through the decision step to the done step.
// A roll that picks table entry k also scans the entries up to k; a removal then closes the gap
// left by the picked entry, as the entries behind it move down one per cycle.
// Throughput: one item at a time; the next is taken once the previous has its result registered.
// Reset (rst_n, synchronous, active low) empties the table, clears the running total, the overflow
// flag and the position numbering; table contents are left as they are and no unwritten entry is used.
module weighted_pick_with_removal #(
  parameter int unsigned MAX_ENTRIES = wpr_pkg::WPR_MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [wpr_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic                          in_first_of_set,
  input  logic [wpr_pkg::WEIGHT_W-1:0]  in_draw,
  input  logic                          in_remove_picked,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wpr_pkg::STATUS_W-1:0]  out_status,
  output logic [wpr_pkg::POS_W-1:0]     out_picked_position,
  output logic [wpr_pkg::LEFT_W-1:0]    out_entries_left,
  output logic [wpr_pkg::WEIGHT_W-1:0]  out_total_weight
);
  import wpr_pkg::*;

  // The controller sequences each item through its decision, the scan of the
  // table and, on request, the compaction that removes the picked entry. The
  // datapath holds the table in a single-port-read memory, the running totals
  // and the output register. An output register stands between the two
  // sides, so an item can be taken while the previous result still waits for
  // its transfer; only delivery of the next result then waits.

  cmd_t cmd;
  sts_t sts;

  wpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The scan reads one entry per cycle and checks it in the next cycle against
  // the running sum; the first entry whose cumulative range holds the draw is
  // the pick. Compaction reads entry j+1 and writes it to j on the next cycle.
  wpr_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_action           (in_action),
    .in_weight           (in_weight),
    .in_first_of_set     (in_first_of_set),
    .in_draw             (in_draw),
    .in_remove_picked    (in_remove_picked),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_status          (out_status),
    .out_picked_position (out_picked_position),
    .out_entries_left    (out_entries_left),
    .out_total_weight    (out_total_weight)
  );

endmodule
